// File: hw/rtl/krt_pkg.sv
// krt_pkg: shared types, codes and helpers for the keyed record table
// used by krt_ctrl, krt_dpath and keyed_record_table; no dependencies
package krt_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int RESULT_LIMIT = 16;
   localparam int USED_W       = 5;

   localparam logic [1:0] OP_ADD  = 2'd0;
   localparam logic [1:0] OP_DEL  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;
   localparam logic [1:0] OP_LIST = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_MISS = 2'd2;

   localparam logic [6:0] GRADE_MAX = 7'd100;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] key_id;
      logic [7:0]  year_in;
      logic [15:0] course_a_in;
      logic [6:0]  grade_a_in;
      logic [15:0] course_b_in;
      logic [6:0]  grade_b_in;
      logic [15:0] course_c_in;
      logic [6:0]  grade_c_in;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [7:0]        year_out;
      logic [15:0]       course_a_out;
      logic [6:0]        grade_a_out;
      logic [15:0]       course_b_out;
      logic [6:0]        grade_b_out;
      logic [15:0]       course_c_out;
      logic [6:0]        grade_c_out;
      logic [15:0]       listed_key;
      logic [USED_W-1:0] used_count;
      logic              table_full;
      logic              last_result;
   } rsp_type;

   typedef struct packed {
      logic [15:0] key;
      logic [7:0]  year;
      logic [15:0] course_a;
      logic [6:0]  grade_a;
      logic [15:0] course_b;
      logic [6:0]  grade_b;
      logic [15:0] course_c;
      logic [6:0]  grade_c;
   } record_type;

   typedef struct packed {
      logic       capture;
      logic       append;
      logic       ptr_clear;
      logic       ptr_inc;
      logic       ptr_load_hit;
      logic       rd_en;
      logic       shift_wr;
      logic       count_dec;
      logic       rsp_load;
      logic [1:0] rsp_status;
      logic       rsp_with_rec;
      logic       rsp_list;
      logic       rsp_last;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic full;
      logic ptr_lt_count;
      logic rd_ok;
      logic hit;
      logic scan_last;
      logic list_last;
   } sts_type;

   function automatic logic [6:0] sat_grade(input logic [6:0] g);
      sat_grade = (g > GRADE_MAX) ? GRADE_MAX : g;
   endfunction

endpackage

// File: hw/rtl/krt_ctrl.sv
// krt_ctrl: sequencing state machine and handshake control for the record table
// depends on krt_pkg; drives krt_dpath through cmd_type, watches sts_type
module krt_ctrl import krt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_op,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  sts_type    sts,
   output cmd_type    cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_ADD      = 3'd1;
   localparam logic [2:0] S_SCAN     = 3'd2;
   localparam logic [2:0] S_SHIFT    = 3'd3;
   localparam logic [2:0] S_LIST_RD  = 3'd4;
   localparam logic [2:0] S_LIST_OUT = 3'd5;
   localparam logic [2:0] S_RESP     = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] op_ff, op_in;
   logic [1:0] resp_status_ff, resp_status_in;
   logic       resp_rec_ff, resp_rec_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      state_in       = state_ff;
      op_in          = op_ff;
      resp_status_in = resp_status_ff;
      resp_rec_in    = resp_rec_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture   = 1'b1;
               cmd.ptr_clear = 1'b1;
               op_in         = req_op;
               case (req_op)
                  OP_ADD:  state_in = S_ADD;
                  OP_LIST: state_in = S_LIST_RD;
                  default: state_in = S_SCAN;
               endcase
            end
         end
         S_ADD: begin
            resp_rec_in = 1'b0;
            if (sts.full) begin
               resp_status_in = ST_FULL;
            end else begin
               cmd.append     = 1'b1;
               resp_status_in = ST_OK;
            end
            state_in = S_RESP;
         end
         S_SCAN: begin
            cmd.rd_en   = sts.ptr_lt_count && !sts.hit;
            cmd.ptr_inc = sts.ptr_lt_count && !sts.hit;
            if (sts.count_zero) begin
               resp_status_in = ST_MISS;
               resp_rec_in    = 1'b0;
               state_in       = S_RESP;
            end else if (sts.hit) begin
               if (op_ff == OP_READ) begin
                  resp_status_in = ST_OK;
                  resp_rec_in    = 1'b1;
                  state_in       = S_RESP;
               end else begin
                  cmd.ptr_load_hit = 1'b1;
                  state_in         = S_SHIFT;
               end
            end else if (sts.scan_last) begin
               resp_status_in = ST_MISS;
               resp_rec_in    = 1'b0;
               state_in       = S_RESP;
            end
         end
         S_SHIFT: begin
            cmd.rd_en    = sts.ptr_lt_count;
            cmd.ptr_inc  = sts.ptr_lt_count;
            cmd.shift_wr = sts.rd_ok;
            if (!sts.ptr_lt_count && !sts.rd_ok) begin
               cmd.count_dec  = 1'b1;
               resp_status_in = ST_OK;
               resp_rec_in    = 1'b0;
               state_in       = S_RESP;
            end
         end
         S_LIST_RD: begin
            if (sts.count_zero) begin
               resp_status_in = ST_MISS;
               resp_rec_in    = 1'b0;
               state_in       = S_RESP;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.ptr_inc = 1'b1;
               state_in    = S_LIST_OUT;
            end
         end
         S_LIST_OUT: begin
            if (slot_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_OK;
               cmd.rsp_list   = 1'b1;
               cmd.rsp_last   = sts.list_last;
               state_in       = sts.list_last ? S_IDLE : S_LIST_RD;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               cmd.rsp_load     = 1'b1;
               cmd.rsp_status   = resp_status_ff;
               cmd.rsp_with_rec = resp_rec_ff;
               cmd.rsp_last     = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      resp_status_ff <= resp_status_in;
      resp_rec_ff    <= resp_rec_in;
   end

endmodule

// File: hw/rtl/krt_dpath.sv
// krt_dpath: record memory, scan pointer, record count and result register
// depends on krt_pkg; commanded by krt_ctrl through cmd_type
module krt_dpath import krt_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_data
);

   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int IW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LIST_N = (CAPACITY < RESULT_LIMIT) ? CAPACITY : RESULT_LIMIT;

   record_type mem [CAPACITY];

   req_type    req_ff;
   record_type rd_data_ff;
   record_type new_rec;
   logic [IW-1:0] rd_idx_ff;
   logic          rd_ok_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] rd_next;
   rsp_type       rsp_ff, rsp_in;

   assign new_rec = '{
      key:      req_ff.key_id,
      year:     req_ff.year_in,
      course_a: req_ff.course_a_in,
      grade_a:  sat_grade(req_ff.grade_a_in),
      course_b: req_ff.course_b_in,
      grade_b:  sat_grade(req_ff.grade_b_in),
      course_c: req_ff.course_c_in,
      grade_c:  sat_grade(req_ff.grade_c_in)
   };

   assign rd_next = CW'(rd_idx_ff) + CW'(1);

   assign sts.count_zero   = (count_ff == '0);
   assign sts.full         = (count_ff == CW'(CAPACITY));
   assign sts.ptr_lt_count = (ptr_ff < count_ff);
   assign sts.rd_ok        = rd_ok_ff;
   assign sts.hit          = rd_ok_ff && (rd_data_ff.key == req_ff.key_id);
   assign sts.scan_last    = rd_ok_ff && (rd_next == count_ff);
   assign sts.list_last    = (rd_next == count_ff) || (rd_next == CW'(LIST_N));

   always_comb begin
      count_in = count_ff;
      if (cmd.append) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.ptr_clear) begin
         ptr_in = '0;
      end else if (cmd.ptr_load_hit) begin
         ptr_in = rd_next;
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_ff + CW'(1);
      end
   end

   always_comb begin
      rsp_in        = '0;
      rsp_in.status = cmd.rsp_status;
      if (cmd.rsp_with_rec) begin
         rsp_in.year_out     = rd_data_ff.year;
         rsp_in.course_a_out = rd_data_ff.course_a;
         rsp_in.grade_a_out  = rd_data_ff.grade_a;
         rsp_in.course_b_out = rd_data_ff.course_b;
         rsp_in.grade_b_out  = rd_data_ff.grade_b;
         rsp_in.course_c_out = rd_data_ff.course_c;
         rsp_in.grade_c_out  = rd_data_ff.grade_c;
      end
      if (cmd.rsp_list) begin
         rsp_in.listed_key = rd_data_ff.key;
      end
      rsp_in.used_count  = USED_W'(count_ff);
      rsp_in.table_full  = sts.full;
      rsp_in.last_result = cmd.rsp_last;
   end

   // record memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         mem[count_ff[IW-1:0]] <= new_rec;
      end else if (cmd.shift_wr) begin
         mem[rd_idx_ff - IW'(1)] <= rd_data_ff;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[ptr_ff[IW-1:0]];
         rd_idx_ff  <= ptr_ff[IW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ptr_ff   <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
         rd_ok_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: hw/rtl/keyed_record_table.sv
// keyed_record_table: top level of the insertion-ordered keyed record table
// depends on krt_pkg, krt_ctrl and krt_dpath
//
//   channel   ports                           direction   payload
//   request   req_valid, req_ready, req_data  in          req_type
//   response  rsp_valid, rsp_ready, rsp_data  out         rsp_type
//
// one transaction at a time; add appends one record; read scans the keys
// one entry a cycle; delete scans the same way, then moves each later record
// down one slot, one move a cycle; list returns one key per response
// a response waits in its register; a stalled response holds the sequencer
// reset clears the record count, scan pointer, read flag, response valid and state; record contents need no clearing
module keyed_record_table import krt_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   krt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.operation),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   krt_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule
